>>> rtl/lsag_pkg.sv
// Shared types, constants and lookup functions for the LED strip animation generator.
// Used by every module of the block and by its checker; depends on nothing.

package lsag_pkg;

  // Field and port widths.
  localparam int PIX_W       = 6;
  localparam int CH_W        = 8;
  localparam int CNT_W       = 32;
  localparam int PHASE_W     = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 32;

  // Default strip length.
  localparam int PIXEL_COUNT_DEF = 16;

  // Counter widths: frames mod 20, frames mod 200, frames mod twice the strip length.
  localparam int K20_W  = 5;
  localparam int M200_W = 8;
  localparam int M2P_W  = 7;

  // Breathing phase step per frame (0.02 rad in a 65536-step turn).
  localparam logic [PHASE_W-1:0] BREATH_STEP = 16'd209;

  // Descriptor queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  // Common levels.
  localparam logic [CH_W-1:0] LVL_FULL       = 8'd255;
  localparam logic [CH_W-1:0] LVL_HALF       = 8'd127;
  localparam logic [CH_W-1:0] LVL_TWO_THIRDS = 8'd170;
  localparam logic [CH_W-1:0] LVL_THIRD      = 8'd85;
  localparam logic [CH_W-1:0] LVL_MID        = 8'd127;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN = 2'd0,
    REG_COLOR   = 2'd1
  } cfg_reg_e;

  // Animation patterns.
  typedef enum logic [CFG_DATA_W-1:0] {
    PAT_OFF       = 4'd0,
    PAT_SOLID     = 4'd1,
    PAT_BREATHING = 4'd2,
    PAT_PULSE     = 4'd3,
    PAT_FLASH     = 4'd4,
    PAT_SPIN      = 4'd5,
    PAT_SWEEP     = 4'd6,
    PAT_CHASE     = 4'd7,
    PAT_ALTERNATE = 4'd8
  } pattern_e;

  // Palette colors.
  typedef enum logic [CFG_DATA_W-1:0] {
    COL_OFF     = 4'd0,
    COL_RED     = 4'd1,
    COL_GREEN   = 4'd2,
    COL_BLUE    = 4'd3,
    COL_YELLOW  = 4'd4,
    COL_CYAN    = 4'd5,
    COL_MAGENTA = 4'd6,
    COL_WHITE   = 4'd7,
    COL_ORANGE  = 4'd8
  } color_e;

  // How the back draws the pixels of one frame.
  typedef enum logic [1:0] {
    DRAW_LEVEL = 2'd0,
    DRAW_SPIN  = 2'd1,
    DRAW_CHASE = 2'd2,
    DRAW_ALT   = 2'd3
  } draw_kind_e;

  typedef struct packed {
    logic [CH_W-1:0] r;
    logic [CH_W-1:0] g;
    logic [CH_W-1:0] b;
  } rgb_t;

  // Everything the back needs to draw one frame.
  typedef struct packed {
    draw_kind_e       kind;
    logic [CH_W-1:0]  level;
    logic [PIX_W-1:0] pos0;
    logic [PIX_W-1:0] pos1;
    logic [PIX_W-1:0] pos2;
    logic             tail_en;
    logic             alt_odd;
    rgb_t             color;
    rgb_t             second;
  } frame_desc_t;

  // Quarter-wave sine, round(127*sin(k*pi/128)) for k = 0..64.
  localparam logic [6:0] QSINE [65] = '{
    7'd0,   7'd3,   7'd6,   7'd9,   7'd12,  7'd16,  7'd19,  7'd22,
    7'd25,  7'd28,  7'd31,  7'd34,  7'd37,  7'd40,  7'd43,  7'd46,
    7'd49,  7'd51,  7'd54,  7'd57,  7'd60,  7'd63,  7'd65,  7'd68,
    7'd71,  7'd73,  7'd76,  7'd78,  7'd81,  7'd83,  7'd85,  7'd88,
    7'd90,  7'd92,  7'd94,  7'd96,  7'd98,  7'd100, 7'd102, 7'd104,
    7'd106, 7'd107, 7'd109, 7'd111, 7'd112, 7'd113, 7'd115, 7'd116,
    7'd117, 7'd118, 7'd120, 7'd121, 7'd122, 7'd122, 7'd123, 7'd124,
    7'd125, 7'd125, 7'd126, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
    7'd127
  };

  // Index must lie in 0..64; larger codes read as zero.
  function automatic logic [6:0] quarter_sine(input logic [6:0] idx);
    logic [6:0] val;
    val = 7'd0;
    if (idx <= 7'd64) begin
      val = QSINE[idx];
    end
    return val;
  endfunction

  // Nine-entry palette; unknown codes are black.
  function automatic rgb_t palette(input logic [CFG_DATA_W-1:0] sel);
    rgb_t c;
    c = '0;
    case (color_e'(sel))
      COL_RED:     c = '{r: 8'd255, g: 8'd0,   b: 8'd0};
      COL_GREEN:   c = '{r: 8'd0,   g: 8'd255, b: 8'd0};
      COL_BLUE:    c = '{r: 8'd0,   g: 8'd0,   b: 8'd255};
      COL_YELLOW:  c = '{r: 8'd255, g: 8'd255, b: 8'd0};
      COL_CYAN:    c = '{r: 8'd0,   g: 8'd255, b: 8'd255};
      COL_MAGENTA: c = '{r: 8'd255, g: 8'd0,   b: 8'd255};
      COL_WHITE:   c = '{r: 8'd255, g: 8'd255, b: 8'd255};
      COL_ORANGE:  c = '{r: 8'd255, g: 8'd165, b: 8'd0};
      default:     c = '0;
    endcase
    return c;
  endfunction

  // Exact floor(x/255) for any product of two 8-bit values.
  function automatic logic [CH_W-1:0] div255(input logic [2*CH_W-1:0] x);
    logic [2*CH_W:0] t;
    t = {1'b0, x} + 17'd1 + {9'd0, x[2*CH_W-1:CH_W]};
    return t[2*CH_W-1:CH_W];
  endfunction

endpackage

>>> rtl/led_strip_animation_generator_top.sv
// Top level of the LED strip animation generator: front, descriptor queue and back.
// Depends on lsag_pkg, lsag_front, lsag_queue and lsag_back.
//
//   Channel  Direction  Word contents
//   s_axis   in         frame_tick (1 = advance one frame, 0 = redraw)
//   m_axis   out        pixel_index, red, green, blue; tlast on the final pixel
//   cfg      in         register 0 pattern_select, register 1 color_select
//
// Each tick yields PIXEL_COUNT output words, set by the back's pixel counter, one per
// cycle while the output is not stalled. A frame's descriptor is written into the
// queue when its tick is taken; each word then passes through back stages 1, 2 and 3.
// Reset clears the counters and selects the off pattern with blue as the color.
// A stalled output freezes the back pipeline; ticks are still taken until the
// two-entry descriptor queue is full.

module led_strip_animation_generator_top #(
  parameter int PIXEL_COUNT = lsag_pkg::PIXEL_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lsag_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lsag_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [0] frame_tick, [7:1] zero
  input  logic [lsag_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [5:0] pixel_index, [13:6] red, [21:14] green, [29:22] blue, [31:30] zero
  output logic [lsag_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  output logic                                m_axis_tlast
);

  logic                  q_full, q_empty, q_push, q_pop;
  lsag_pkg::frame_desc_t push_desc, head_desc;

  lsag_front #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .tick_valid_i (s_axis_tvalid),
    .tick_i       (s_axis_tdata[0]),
    .tick_ready_o (s_axis_tready),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_desc_o     (push_desc)
  );

  lsag_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_desc_i (push_desc),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (head_desc)
  );

  lsag_back #(
    .PIXEL_COUNT (PIXEL_COUNT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .empty_i       (q_empty),
    .head_i        (head_desc),
    .pop_o         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

>>> rtl/lsag_front.sv
// Front of the LED strip animation generator: configuration registers, frame counters,
// and per-frame classification into a draw descriptor. Depends on lsag_pkg.

module lsag_front #(
  parameter int PIXEL_COUNT = lsag_pkg::PIXEL_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lsag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [lsag_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             tick_valid_i,
  input  logic                             tick_i,
  output logic                             tick_ready_o,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output lsag_pkg::frame_desc_t            q_desc_o
);

  localparam logic [lsag_pkg::M2P_W-1:0]  M2P_LAST  = lsag_pkg::M2P_W'(2 * PIXEL_COUNT - 1);
  localparam logic [lsag_pkg::PIX_W-1:0]  PIX_LAST  = lsag_pkg::PIX_W'(PIXEL_COUNT - 1);
  localparam logic [lsag_pkg::PIX_W-1:0]  PIX_LAST2 = lsag_pkg::PIX_W'(PIXEL_COUNT - 2);

  logic [lsag_pkg::CFG_DATA_W-1:0] pattern_q, pattern_d;
  logic [lsag_pkg::CFG_DATA_W-1:0] color_q, color_d;
  logic [lsag_pkg::CNT_W-1:0]      frame_cnt_q, frame_cnt_d;
  logic [lsag_pkg::PHASE_W-1:0]    phase_q, phase_d;
  logic [lsag_pkg::K20_W-1:0]      k20_q, k20_d;
  logic [lsag_pkg::M200_W-1:0]     m200_q, m200_d;
  logic [lsag_pkg::M2P_W-1:0]      m2p_q, m2p_d;

  logic pattern_wr, color_wr, accept, advance, cnt_wrap;

  // Configuration decode.
  always_comb begin
    pattern_wr = 1'b0;
    color_wr   = 1'b0;
    if (cfg_we_i) begin
      unique case (lsag_pkg::cfg_reg_e'(cfg_index_i))
        lsag_pkg::REG_PATTERN: pattern_wr = 1'b1;
        lsag_pkg::REG_COLOR:   color_wr   = 1'b1;
        default:               ;
      endcase
    end
  end

  assign tick_ready_o = !q_full_i;
  assign accept       = tick_valid_i && !q_full_i;
  assign advance      = accept && tick_i;
  assign q_push_o     = accept;

  // The residue counters restart together with the frame counter when it wraps.
  assign cnt_wrap     = (frame_cnt_q == '1);

  // Next values of the registers; a pattern write restarts the animation.
  always_comb begin
    pattern_d   = pattern_wr ? cfg_data_i : pattern_q;
    color_d     = color_wr ? cfg_data_i : color_q;
    frame_cnt_d = frame_cnt_q;
    phase_d     = phase_q;
    k20_d       = k20_q;
    m200_d      = m200_q;
    m2p_d       = m2p_q;
    if (pattern_wr) begin
      frame_cnt_d = '0;
      phase_d     = '0;
      k20_d       = '0;
      m200_d      = '0;
      m2p_d       = '0;
    end else if (advance) begin
      frame_cnt_d = frame_cnt_q + 32'd1;
      phase_d     = phase_q + lsag_pkg::BREATH_STEP;
      k20_d       = (cnt_wrap || (k20_q == 5'd19)) ? '0 : k20_q + 5'd1;
      m200_d      = (cnt_wrap || (m200_q == 8'd199)) ? '0 : m200_q + 8'd1;
      m2p_d       = (cnt_wrap || (m2p_q == M2P_LAST)) ? '0 : m2p_q + 7'd1;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q   <= lsag_pkg::PAT_OFF;
      color_q     <= lsag_pkg::COL_BLUE;
      frame_cnt_q <= '0;
      phase_q     <= '0;
      k20_q       <= '0;
      m200_q      <= '0;
      m2p_q       <= '0;
    end else begin
      pattern_q   <= pattern_d;
      color_q     <= color_d;
      frame_cnt_q <= frame_cnt_d;
      phase_q     <= phase_d;
      k20_q       <= k20_d;
      m200_q      <= m200_d;
      m2p_q       <= m2p_d;
    end
  end

  // Per-frame quantities, taken from the counters as they stand after this tick.
  logic                          first;
  logic                          five_odd;
  logic [7:0]                    bphase;
  logic [6:0]                    sidx;
  logic [6:0]                    sval;
  logic [lsag_pkg::CH_W-1:0]     breath_lvl;
  logic [lsag_pkg::K20_W-1:0]    kk;
  logic [12:0]                   pulse_prod;
  logic [6:0]                    f, ff;
  logic [9:0]                    sweep_prod;
  logic [lsag_pkg::PIX_W-1:0]    q, q1, q2;

  always_comb begin
    first    = (frame_cnt_d == '0);
    // floor(n/5) is odd exactly when n mod 20 falls in 5..9 or 15..19.
    five_odd = ((k20_d >= 5'd5) && (k20_d < 5'd10)) || (k20_d >= 5'd15);

    // Breathing: fold the top phase byte onto the quarter wave.
    bphase = phase_d[15:8];
    if (bphase < 8'd64) begin
      sidx = bphase[6:0];
    end else if (bphase < 8'd128) begin
      sidx = 7'(8'd128 - bphase);
    end else if (bphase < 8'd192) begin
      sidx = 7'(bphase - 8'd128);
    end else begin
      sidx = 7'(9'd256 - {1'b0, bphase});
    end
    sval = lsag_pkg::quarter_sine(sidx);
    breath_lvl = bphase[7] ? (lsag_pkg::LVL_MID - {1'b0, sval})
                           : (lsag_pkg::LVL_MID + {1'b0, sval});

    // Pulse triangle over twenty frames.
    kk         = (k20_d < 5'd10) ? k20_d : 5'(5'd20 - k20_d);
    pulse_prod = kk * 8'd25;

    // Sweep ramp over a hundred half-rate steps.
    f          = m200_d[7:1];
    ff         = (f < 7'd50) ? f : 7'(7'd100 - f);
    sweep_prod = ff * 3'd5;

    // Spin and chase head position and the two pixels behind it, wrapped.
    q  = m2p_d[lsag_pkg::M2P_W-1:1];
    q1 = (q == '0) ? PIX_LAST : q - 6'd1;
    q2 = (q == '0) ? PIX_LAST2 : ((q == 6'd1) ? PIX_LAST : q - 6'd2);
  end

  // Classification of the pattern into a draw descriptor.
  always_comb begin
    q_desc_o         = '0;
    q_desc_o.kind    = lsag_pkg::DRAW_LEVEL;
    q_desc_o.pos0    = q;
    q_desc_o.pos1    = q1;
    q_desc_o.pos2    = q2;
    q_desc_o.tail_en = (q != '0);
    q_desc_o.alt_odd = five_odd;
    q_desc_o.color   = lsag_pkg::palette(color_q);
    q_desc_o.second  = lsag_pkg::palette((color_q == lsag_pkg::COL_RED) ?
                                         lsag_pkg::COL_BLUE : lsag_pkg::COL_RED);
    unique case (lsag_pkg::pattern_e'(pattern_q))
      lsag_pkg::PAT_OFF:       q_desc_o.level = '0;
      lsag_pkg::PAT_SOLID:     q_desc_o.level = lsag_pkg::LVL_FULL;
      lsag_pkg::PAT_BREATHING: q_desc_o.level = first ? '0 : breath_lvl;
      lsag_pkg::PAT_PULSE:     q_desc_o.level = pulse_prod[7:0];
      lsag_pkg::PAT_FLASH:     q_desc_o.level = (first || five_odd) ? lsag_pkg::LVL_FULL : '0;
      lsag_pkg::PAT_SPIN:      q_desc_o.kind  = first ? lsag_pkg::DRAW_LEVEL
                                                      : lsag_pkg::DRAW_SPIN;
      lsag_pkg::PAT_SWEEP:     q_desc_o.level = first ? lsag_pkg::LVL_FULL : sweep_prod[7:0];
      lsag_pkg::PAT_CHASE:     q_desc_o.kind  = first ? lsag_pkg::DRAW_LEVEL
                                                      : lsag_pkg::DRAW_CHASE;
      lsag_pkg::PAT_ALTERNATE: q_desc_o.kind  = lsag_pkg::DRAW_ALT;
      default:                 q_desc_o.level = '0;
    endcase
  end

endmodule

>>> rtl/lsag_queue.sv
// Two-entry descriptor queue between the front and the back of the generator.
// Depends on lsag_pkg for the descriptor type and depth.

module lsag_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  lsag_pkg::frame_desc_t push_desc_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  empty_o,
  output lsag_pkg::frame_desc_t head_o
);

  localparam int CNT_W = lsag_pkg::QPTR_W + 1;

  lsag_pkg::frame_desc_t             entry_q [lsag_pkg::QUEUE_DEPTH];
  logic [lsag_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d;
  logic [lsag_pkg::QPTR_W-1:0]       rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]                  count_q, count_d;

  assign full_o  = (count_q == CNT_W'(lsag_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill-level update.
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_desc_i;
    end
  end

endmodule

>>> rtl/lsag_back.sv
// Back of the generator: walks the pixels of the queued frame, picks level and color,
// scales each channel by level/255 in a three-stage pipeline. Depends on lsag_pkg.

module lsag_back #(
  parameter int PIXEL_COUNT = lsag_pkg::PIXEL_COUNT_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  lsag_pkg::frame_desc_t                head_i,
  output logic                                 pop_o,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [lsag_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  output logic                                 m_axis_tlast
);

  localparam logic [lsag_pkg::PIX_W-1:0] PIX_LAST = lsag_pkg::PIX_W'(PIXEL_COUNT - 1);

  logic                          advance, take, pix_last;
  logic [lsag_pkg::PIX_W-1:0]    pix_q, pix_d;

  // The whole pipeline moves when the output word is free or being taken.
  assign advance  = !m_axis_tvalid || m_axis_tready;
  assign take     = advance && !empty_i;
  assign pix_last = (pix_q == PIX_LAST);
  assign pop_o    = take && pix_last;

  always_comb begin
    pix_d = pix_q;
    if (take) begin
      pix_d = pix_last ? '0 : pix_q + 6'd1;
    end
  end

  // Level and base color of the current pixel.
  logic [lsag_pkg::CH_W-1:0] lvl;
  lsag_pkg::rgb_t            rgb;

  always_comb begin
    lvl = '0;
    rgb = head_i.color;
    unique case (head_i.kind)
      lsag_pkg::DRAW_LEVEL: begin
        lvl = head_i.level;
      end
      lsag_pkg::DRAW_SPIN: begin
        // A level of 127 gives c/2 for every palette channel value.
        if (pix_q == head_i.pos0) begin
          lvl = lsag_pkg::LVL_FULL;
        end else if (head_i.tail_en && (pix_q == head_i.pos1)) begin
          lvl = lsag_pkg::LVL_HALF;
        end
      end
      lsag_pkg::DRAW_CHASE: begin
        if (pix_q == head_i.pos0) begin
          lvl = lsag_pkg::LVL_FULL;
        end else if (pix_q == head_i.pos1) begin
          lvl = lsag_pkg::LVL_TWO_THIRDS;
        end else if (pix_q == head_i.pos2) begin
          lvl = lsag_pkg::LVL_THIRD;
        end
      end
      lsag_pkg::DRAW_ALT: begin
        lvl = lsag_pkg::LVL_FULL;
        rgb = (pix_q[0] ^ head_i.alt_odd) ? head_i.color : head_i.second;
      end
      default: ;
    endcase
  end

  // Stage 1: selected level and color.
  logic                          s1_valid_q;
  logic                          s1_last_q;
  logic [lsag_pkg::PIX_W-1:0]    s1_idx_q;
  logic [lsag_pkg::CH_W-1:0]     s1_lvl_q;
  lsag_pkg::rgb_t                s1_rgb_q;

  // Stage 2: raw channel products.
  logic                          s2_valid_q;
  logic                          s2_last_q;
  logic [lsag_pkg::PIX_W-1:0]    s2_idx_q;
  logic [2*lsag_pkg::CH_W-1:0]   s2_r_q, s2_g_q, s2_b_q;

  // Stage 3: output word.
  logic                          out_valid_q;
  logic                          out_last_q;
  logic [lsag_pkg::PIX_W-1:0]    out_idx_q;
  logic [lsag_pkg::CH_W-1:0]     out_r_q, out_g_q, out_b_q;

  // Control state of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pix_q <= pix_d;
      if (advance) begin
        s1_valid_q  <= take;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= s2_valid_q;
      end
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_last_q  <= pix_last;
      s1_idx_q   <= pix_q;
      s1_lvl_q   <= lvl;
      s1_rgb_q   <= rgb;
      s2_last_q  <= s1_last_q;
      s2_idx_q   <= s1_idx_q;
      s2_r_q     <= s1_rgb_q.r * s1_lvl_q;
      s2_g_q     <= s1_rgb_q.g * s1_lvl_q;
      s2_b_q     <= s1_rgb_q.b * s1_lvl_q;
      out_last_q <= s2_last_q;
      out_idx_q  <= s2_idx_q;
      out_r_q    <= lsag_pkg::div255(s2_r_q);
      out_g_q    <= lsag_pkg::div255(s2_g_q);
      out_b_q    <= lsag_pkg::div255(s2_b_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_b_q, out_g_q, out_r_q, out_idx_q};

endmodule

>>> rtl/lsag_checker.sv
// Port-level checker for the LED strip animation generator, bound to the top level.
// Depends on lsag_pkg and led_strip_animation_generator_top.

module lsag_checker #(
  parameter int PIXEL_COUNT = lsag_pkg::PIXEL_COUNT_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [lsag_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input logic                              m_axis_tlast
);

  localparam logic [lsag_pkg::PIX_W-1:0] PIX_LAST = lsag_pkg::PIX_W'(PIXEL_COUNT - 1);

  logic                        in_acc, out_acc;
  logic [lsag_pkg::PIX_W-1:0]  out_idx;
  logic [lsag_pkg::PIX_W-1:0]  exp_idx_q, exp_idx_d;
  logic [3:0]                  pending_q, pending_d;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign out_idx = m_axis_tdata[lsag_pkg::PIX_W-1:0];

  // Expected next pixel index and the number of frames still owed.
  always_comb begin
    exp_idx_d = exp_idx_q;
    if (out_acc) begin
      exp_idx_d = m_axis_tlast ? '0 : out_idx + 6'd1;
    end
    pending_d = pending_q + {3'd0, in_acc} - {3'd0, out_acc && m_axis_tlast};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_idx_q <= '0;
      pending_q <= '0;
    end else begin
      exp_idx_q <= exp_idx_d;
      pending_q <= pending_d;
    end
  end

  // Pixels come out in strip order, starting again after each frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_idx == exp_idx_q))
    else $error("pixel index out of sequence");

  // The frame marker sits on the final pixel and nowhere else.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (out_idx == PIX_LAST)))
    else $error("frame marker misplaced");

  // No frame is finished without a tick taken for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && m_axis_tlast) |-> (pending_q != 4'd0))
    else $error("frame emitted without a tick");

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)))
    else $error("stalled output word changed");

endmodule

bind led_strip_animation_generator_top lsag_checker #(
  .PIXEL_COUNT (PIXEL_COUNT)
) u_lsag_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
